>>> rtl/core/lav_pkg.sv
// Shared types and constants for the look-at view matrix block.
package lav_pkg;

	// Width of every coordinate and matrix element
	localparam int FIELD_W = 32;
	// Magnitudes are normalized into [2^30, 2^31) before the square root
	localparam int NORM_W = 31;
	// Integer square root of a 64-bit sum yields this many bits
	localparam int ROOT_W = 32;

	// Row codes of the emitted matrix
	localparam logic [1:0] ROW_X    = 2'd0;
	localparam logic [1:0] ROW_Y    = 2'd1;
	localparam logic [1:0] ROW_Z    = 2'd2;
	localparam logic [1:0] ROW_LAST = 2'd3;

	// One camera setup request
	typedef struct packed {
		logic signed [FIELD_W-1:0] eye_x;
		logic signed [FIELD_W-1:0] eye_y;
		logic signed [FIELD_W-1:0] eye_z;
		logic signed [FIELD_W-1:0] target_x;
		logic signed [FIELD_W-1:0] target_y;
		logic signed [FIELD_W-1:0] target_z;
		logic signed [FIELD_W-1:0] up_x;
		logic signed [FIELD_W-1:0] up_y;
		logic signed [FIELD_W-1:0] up_z;
	} lav_in_t;

	// One matrix row
	typedef struct packed {
		logic [1:0]                row_index;
		logic signed [FIELD_W-1:0] col0;
		logic signed [FIELD_W-1:0] col1;
		logic signed [FIELD_W-1:0] col2;
		logic signed [FIELD_W-1:0] col3;
		logic                      degenerate;
		logic                      last_row;
	} lav_out_t;

endpackage

>>> rtl/core/lav_norm.sv
// Pipelined 3-vector normalizer: magnitude, scale, square root, divide.
module lav_norm #(
	parameter int IN_W      = 33,
	parameter int SIDE_W    = 1,
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [IN_W-1:0]   in_vec [3],
	input  logic [SIDE_W-1:0]        in_side,
	output logic                     out_valid,
	output logic signed [FRAC_BITS+1:0] out_vec [3],
	output logic                     out_zero,
	output logic [SIDE_W-1:0]        out_side
);
	import lav_pkg::*;

	localparam int NW    = (IN_W < NORM_W) ? NORM_W : IN_W;
	localparam int SH    = $clog2(NW);
	localparam int SQ_W  = 2 * NORM_W;
	localparam int SUM_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 4;
	localparam int QW    = FRAC_BITS + 1;
	localparam int NUMW  = ROOT_W + FRAC_BITS;
	localparam int OW    = FRAC_BITS + 2;
	localparam int XW    = SIDE_W + 3;
	localparam int LAT   = SH + 6 + ROOT_W + QW;

	// Valid bits and sideband (user data plus component signs) for every stage
	logic [LAT:1]   vld_s;
	logic [XW-1:0]  xs_s [1:LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xs_s[1] <= {in_side, in_vec[2][IN_W-1], in_vec[1][IN_W-1], in_vec[0][IN_W-1]};
			for (int k = 2; k <= LAT; k++) begin
				xs_s[k] <= xs_s[k-1];
			end
		end
	end

	// Stage 1: take component magnitudes
	logic [IN_W-1:0] mag_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= in_vec[i][IN_W-1] ? IN_W'(-in_vec[i]) : IN_W'(in_vec[i]);
			end
		end
	end

	// Stage 2: find the largest magnitude; entry 3 holds it during the shift
	logic [IN_W-1:0] m01, mx;
	logic [NW-1:0]   sh_s [0:SH][4];

	always_comb begin
		m01 = (mag_s1[0] > mag_s1[1]) ? mag_s1[0] : mag_s1[1];
		mx  = (m01 > mag_s1[2]) ? m01 : mag_s1[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				sh_s[0][j] <= NW'(mag_s1[j]);
			end
			sh_s[0][3] <= NW'(mx);
		end
	end

	// Left-normalize all three by a common amount, one power of two a stage
	for (genvar k = 1; k <= SH; k++) begin : g_shift
		localparam int STEP = 1 << (SH - k);
		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 4; j++) begin
					sh_s[k][j] <= (sh_s[k-1][3][NW-1 -: STEP] == '0) ?
						(sh_s[k-1][j] << STEP) : sh_s[k-1][j];
				end
			end
		end
	end

	// Keep the top bits: the largest magnitude now lies in [2^30, 2^31)
	logic [NORM_W-1:0] a_top [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			a_top[j] = sh_s[SH][j][NW-1 -: NORM_W];
		end
	end

	// Square the scaled magnitudes
	logic [SQ_W-1:0]   sq_s  [3];
	logic [NORM_W-1:0] asq_s [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				sq_s[j]  <= a_top[j] * a_top[j];
				asq_s[j] <= a_top[j];
			end
		end
	end

	// Sum the squares
	logic [SUM_W-1:0]  sum_s;
	logic [NORM_W-1:0] asu_s [3];

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s <= SUM_W'(sq_s[0]) + SUM_W'(sq_s[1]) + SUM_W'(sq_s[2]);
			for (int j = 0; j < 3; j++) begin
				asu_s[j] <= asq_s[j];
			end
		end
	end

	// Integer square root, one result bit a stage
	logic [REM_W-1:0]  rt_rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0] rt_root_s [1:ROOT_W];
	logic [SUM_W-1:0]  rt_rad_s  [1:ROOT_W];
	logic [NORM_W-1:0] rt_a_s    [1:ROOT_W][3];

	for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
		logic [REM_W-1:0]  rem_p, rin, trial;
		logic [ROOT_W-1:0] root_p;
		logic [SUM_W-1:0]  rad_p;
		logic [NORM_W-1:0] a_p [3];
		logic              ge;

		if (k == 1) begin : g_src
			always_comb begin
				rem_p  = '0;
				root_p = '0;
				rad_p  = sum_s;
				for (int j = 0; j < 3; j++) begin
					a_p[j] = asu_s[j];
				end
			end
		end else begin : g_src
			always_comb begin
				rem_p  = rt_rem_s[k-1];
				root_p = rt_root_s[k-1];
				rad_p  = rt_rad_s[k-1];
				for (int j = 0; j < 3; j++) begin
					a_p[j] = rt_a_s[k-1][j];
				end
			end
		end

		always_comb begin
			rin   = {rem_p[REM_W-3:0], rad_p[SUM_W-1 -: 2]};
			trial = {2'b00, root_p, 2'b01};
			ge    = (rin >= trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem_s[k]  <= ge ? (rin - trial) : rin;
				rt_root_s[k] <= {root_p[ROOT_W-2:0], ge};
				rt_rad_s[k]  <= rad_p << 2;
				for (int j = 0; j < 3; j++) begin
					rt_a_s[k][j] <= a_p[j];
				end
			end
		end
	end

	// Form the rounded dividends
	logic [NUMW-1:0]   num_s [3];
	logic [ROOT_W-1:0] len_s;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				num_s[j] <= {1'b0, rt_a_s[ROOT_W][j], {FRAC_BITS{1'b0}}} +
					NUMW'(rt_root_s[ROOT_W][ROOT_W-1:1]);
			end
			len_s <= rt_root_s[ROOT_W];
		end
	end

	// Restoring division by the length, one quotient bit a stage
	logic [NUMW-1:0]   dv_rem_s [1:QW][3];
	logic [QW-1:0]     dv_q_s   [1:QW][3];
	logic [ROOT_W-1:0] dv_len_s [1:QW];

	for (genvar k = 1; k <= QW; k++) begin : g_div
		localparam int BIT = QW - k;
		logic [NUMW-1:0]   rem_p [3];
		logic [QW-1:0]     q_p   [3];
		logic [ROOT_W-1:0] len_p;
		logic [NUMW-1:0]   dvs;

		if (k == 1) begin : g_src
			always_comb begin
				len_p = len_s;
				for (int j = 0; j < 3; j++) begin
					rem_p[j] = num_s[j];
					q_p[j]   = '0;
				end
			end
		end else begin : g_src
			always_comb begin
				len_p = dv_len_s[k-1];
				for (int j = 0; j < 3; j++) begin
					rem_p[j] = dv_rem_s[k-1][j];
					q_p[j]   = dv_q_s[k-1][j];
				end
			end
		end

		assign dvs = NUMW'(len_p) << BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				dv_len_s[k] <= len_p;
				for (int j = 0; j < 3; j++) begin
					if (rem_p[j] >= dvs) begin
						dv_rem_s[k][j] <= rem_p[j] - dvs;
						dv_q_s[k][j]   <= {q_p[j][QW-2:0], 1'b1};
					end else begin
						dv_rem_s[k][j] <= rem_p[j];
						dv_q_s[k][j]   <= {q_p[j][QW-2:0], 1'b0};
					end
				end
			end
		end
	end

	// Restore signs; a zero-length vector gives zero
	logic signed [OW-1:0] vec_s [3];
	logic                 zero_s;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s <= (dv_len_s[QW] == '0);
			for (int j = 0; j < 3; j++) begin
				if (dv_len_s[QW] == '0) begin
					vec_s[j] <= '0;
				end else if (xs_s[LAT-1][j]) begin
					vec_s[j] <= -$signed({1'b0, dv_q_s[QW][j]});
				end else begin
					vec_s[j] <= $signed({1'b0, dv_q_s[QW][j]});
				end
			end
		end
	end

	assign out_valid = vld_s[LAT];
	assign out_vec   = vec_s;
	assign out_zero  = zero_s;
	assign out_side  = xs_s[LAT][XW-1:3];

endmodule

>>> rtl/core/lookat_view_matrix_top.sv
// Left-handed look-at view matrix generator, top level.
//
// Input channel in_valid/in_ready/in_data carries one camera request: eye,
// target and up hint, each signed fixed point with FRAC_BITS fraction bits.
// Output channel out_valid/out_ready/out_data returns four row requests per
// camera, rows 0 to 3 in order, last_row marking row 3; degenerate is set on
// all four rows when any normalized vector had zero length.
// The datapath is one long pipeline: a difference stage, three normalizers
// (each 3 + ceil(log2 width) + 32 square-root + FRAC_BITS+1 divide +
// 3 stages), two cross-product stages pairs and five row-3 dot stages.
// A request may enter every cycle while in_ready is high, and the output register
// emits one row per cycle while out_ready is high, so it takes a new camera only
// as the last row of the camera it holds is accepted.
// When out_ready is low the output row holds; once the last pipeline stage
// also holds a finished camera, the whole pipeline freezes and in_ready
// drops, so nothing is lost or repeated. Reset clears all valid bits and the
// row counter; no clearing pass is needed.
module lookat_view_matrix_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lav_pkg::lav_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output lav_pkg::lav_out_t out_data
);
	import lav_pkg::*;

	localparam int OW     = FRAC_BITS + 2;
	localparam int L_W    = FIELD_W + 1;
	localparam int PW1    = FIELD_W + OW;
	localparam int C1_W   = PW1 + 1;
	localparam int PW2    = 2 * OW;
	localparam int C2_W   = PW2 + 1;
	localparam int DW     = FIELD_W + OW + 2;
	localparam int QRW    = DW + 1 - FRAC_BITS;
	localparam int EYE_W  = 3 * FIELD_W;
	localparam int VEC_W  = 3 * OW;
	localparam int SD1_W  = EYE_W + VEC_W + 1;
	localparam int SD2_W  = EYE_W + 2 * VEC_W + 1;
	localparam int MAT_W  = 3 * VEC_W + 1;
	localparam logic [DW:0]    HALF    = (DW + 1)'(1) << (FRAC_BITS - 1);
	localparam logic [QRW-1:0] POS_LIM = QRW'(64'h0000_0000_7FFF_FFFF);
	localparam logic [QRW-1:0] NEG_LIM = QRW'(64'h0000_0000_8000_0000);

	logic en, take;

	// Stage 1: capture the request, form the look direction
	logic                     vld_s1;
	logic signed [L_W-1:0]    l_s1 [3];
	logic [EYE_W-1:0]         eye_s1, up_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s1[0] <= L_W'(in_data.target_x) - L_W'(in_data.eye_x);
			l_s1[1] <= L_W'(in_data.target_y) - L_W'(in_data.eye_y);
			l_s1[2] <= L_W'(in_data.target_z) - L_W'(in_data.eye_z);
			eye_s1  <= {in_data.eye_z, in_data.eye_y, in_data.eye_x};
			up_s1   <= {in_data.up_z, in_data.up_y, in_data.up_x};
		end
	end

	// Normalize the look axis
	logic                  n0_valid, n0_zero;
	logic signed [OW-1:0]  n0_vec [3];
	logic [2*EYE_W-1:0]    n0_side;

	lav_norm #(
		.IN_W      (L_W),
		.SIDE_W    (2 * EYE_W),
		.FRAC_BITS (FRAC_BITS)
	) u_norm_look (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.in_vec    (l_s1),
		.in_side   ({up_s1, eye_s1}),
		.out_valid (n0_valid),
		.out_vec   (n0_vec),
		.out_zero  (n0_zero),
		.out_side  (n0_side)
	);

	// Stage 2: products for right = up x look
	logic signed [FIELD_W-1:0] up_v [3];
	logic                      vld_s2, deg_s2;
	logic signed [PW1-1:0]     pa_s2 [3], pb_s2 [3];
	logic signed [OW-1:0]      l_s2 [3];
	logic [EYE_W-1:0]          eye_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			up_v[i] = $signed(n0_side[EYE_W + i*FIELD_W +: FIELD_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= n0_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s2[0] <= up_v[1] * n0_vec[2];
			pb_s2[0] <= up_v[2] * n0_vec[1];
			pa_s2[1] <= up_v[2] * n0_vec[0];
			pb_s2[1] <= up_v[0] * n0_vec[2];
			pa_s2[2] <= up_v[0] * n0_vec[1];
			pb_s2[2] <= up_v[1] * n0_vec[0];
			l_s2     <= n0_vec;
			eye_s2   <= n0_side[EYE_W-1:0];
			deg_s2   <= n0_zero;
		end
	end

	// Stage 3: differences for right
	logic                    vld_s3, deg_s3;
	logic signed [C1_W-1:0]  c1_s3 [3];
	logic signed [OW-1:0]    l_s3 [3];
	logic [EYE_W-1:0]        eye_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c1_s3[i] <= C1_W'(pa_s2[i]) - C1_W'(pb_s2[i]);
			end
			l_s3   <= l_s2;
			eye_s3 <= eye_s2;
			deg_s3 <= deg_s2;
		end
	end

	// Normalize the right axis
	logic                  n1_valid, n1_zero;
	logic signed [OW-1:0]  n1_vec [3];
	logic [SD1_W-1:0]      n1_side;

	lav_norm #(
		.IN_W      (C1_W),
		.SIDE_W    (SD1_W),
		.FRAC_BITS (FRAC_BITS)
	) u_norm_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_vec    (c1_s3),
		.in_side   ({eye_s3, l_s3[2], l_s3[1], l_s3[0], deg_s3}),
		.out_valid (n1_valid),
		.out_vec   (n1_vec),
		.out_zero  (n1_zero),
		.out_side  (n1_side)
	);

	// Stage 4: products for true up = look x right
	logic signed [OW-1:0]  l1_v [3];
	logic                  vld_s4, deg_s4;
	logic signed [PW2-1:0] pa_s4 [3], pb_s4 [3];
	logic signed [OW-1:0]  l_s4 [3], r_s4 [3];
	logic [EYE_W-1:0]      eye_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			l1_v[i] = $signed(n1_side[1 + i*OW +: OW]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= n1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s4[0] <= l1_v[1] * n1_vec[2];
			pb_s4[0] <= l1_v[2] * n1_vec[1];
			pa_s4[1] <= l1_v[2] * n1_vec[0];
			pb_s4[1] <= l1_v[0] * n1_vec[2];
			pa_s4[2] <= l1_v[0] * n1_vec[1];
			pb_s4[2] <= l1_v[1] * n1_vec[0];
			l_s4     <= l1_v;
			r_s4     <= n1_vec;
			eye_s4   <= n1_side[1 + VEC_W +: EYE_W];
			deg_s4   <= n1_side[0] | n1_zero;
		end
	end

	// Stage 5: differences for true up
	logic                    vld_s5, deg_s5;
	logic signed [C2_W-1:0]  c2_s5 [3];
	logic signed [OW-1:0]    l_s5 [3], r_s5 [3];
	logic [EYE_W-1:0]        eye_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c2_s5[i] <= C2_W'(pa_s4[i]) - C2_W'(pb_s4[i]);
			end
			l_s5   <= l_s4;
			r_s5   <= r_s4;
			eye_s5 <= eye_s4;
			deg_s5 <= deg_s4;
		end
	end

	// Normalize the true up axis
	logic                  n2_valid, n2_zero;
	logic signed [OW-1:0]  n2_vec [3];
	logic [SD2_W-1:0]      n2_side;

	lav_norm #(
		.IN_W      (C2_W),
		.SIDE_W    (SD2_W),
		.FRAC_BITS (FRAC_BITS)
	) u_norm_up (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s5),
		.in_vec    (c2_s5),
		.in_side   ({eye_s5, l_s5[2], l_s5[1], l_s5[0], r_s5[2], r_s5[1], r_s5[0], deg_s5}),
		.out_valid (n2_valid),
		.out_vec   (n2_vec),
		.out_zero  (n2_zero),
		.out_side  (n2_side)
	);

	// Stage 6: products for the eye dot products; gather the axes
	logic signed [OW-1:0]      ax_v  [3][3];
	logic signed [FIELD_W-1:0] eye_v [3];
	logic                      vld_s6;
	logic signed [PW1-1:0]     pr_s6 [3][3];
	logic [MAT_W-1:0]          mat_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ax_v[0][i] = $signed(n2_side[1 + i*OW +: OW]);
			ax_v[1][i] = n2_vec[i];
			ax_v[2][i] = $signed(n2_side[1 + VEC_W + i*OW +: OW]);
			eye_v[i]   = $signed(n2_side[1 + 2*VEC_W + i*FIELD_W +: FIELD_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= n2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 3; v++) begin
				for (int i = 0; i < 3; i++) begin
					pr_s6[v][i] <= ax_v[v][i] * eye_v[i];
				end
			end
			mat_s6 <= {n2_side[1 + VEC_W +: VEC_W], n2_vec[2], n2_vec[1], n2_vec[0],
				n2_side[1 +: VEC_W], n2_side[0] | n2_zero};
		end
	end

	// Stage 7: sum the dot products
	logic                  vld_s7;
	logic signed [DW-1:0]  dot_s7 [3];
	logic [MAT_W-1:0]      mat_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 3; v++) begin
				dot_s7[v] <= DW'(pr_s6[v][0]) + DW'(pr_s6[v][1]) + DW'(pr_s6[v][2]);
			end
			mat_s7 <= mat_s6;
		end
	end

	// Stage 8: split into sign and magnitude
	logic              vld_s8;
	logic [DW-1:0]     dm_s8 [3];
	logic [2:0]        dneg_s8;
	logic [MAT_W-1:0]  mat_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 3; v++) begin
				dm_s8[v]   <= dot_s7[v][DW-1] ? DW'(-dot_s7[v]) : DW'(dot_s7[v]);
				dneg_s8[v] <= dot_s7[v][DW-1];
			end
			mat_s8 <= mat_s7;
		end
	end

	// Stage 9: round the magnitude to the output scale, halves up
	logic [DW:0]       rnd [3];
	logic              vld_s9;
	logic [QRW-1:0]    qr_s9 [3];
	logic [2:0]        dneg_s9;
	logic [MAT_W-1:0]  mat_s9;

	always_comb begin
		for (int v = 0; v < 3; v++) begin
			rnd[v] = {1'b0, dm_s8[v]} + HALF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 3; v++) begin
				qr_s9[v] <= rnd[v][DW:FRAC_BITS];
			end
			dneg_s9 <= dneg_s8;
			mat_s9  <= mat_s8;
		end
	end

	// Stage 10: negate and saturate to 32 bits
	logic                      vld_s10;
	logic signed [FIELD_W-1:0] dot_s10 [3];
	logic [MAT_W-1:0]          mat_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 3; v++) begin
				if (dneg_s9[v]) begin
					dot_s10[v] <= (qr_s9[v] > POS_LIM) ? POS_LIM[FIELD_W-1:0] :
						qr_s9[v][FIELD_W-1:0];
				end else begin
					dot_s10[v] <= (qr_s9[v] > NEG_LIM) ? NEG_LIM[FIELD_W-1:0] :
						-qr_s9[v][FIELD_W-1:0];
				end
			end
			mat_s10 <= mat_s9;
		end
	end

	// Output register: hold one camera and step through its four rows
	logic                      ser_vld_q;
	logic [1:0]                row_q;
	logic [MAT_W-1:0]          mat_q;
	logic signed [FIELD_W-1:0] dot_q [3];

	assign take     = !ser_vld_q || (out_ready && (row_q == ROW_LAST));
	assign en       = !vld_s10 || take;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_vld_q <= 1'b0;
			row_q     <= ROW_X;
		end else if (take) begin
			ser_vld_q <= vld_s10;
			row_q     <= ROW_X;
		end else if (out_ready) begin
			row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mat_q <= mat_s10;
			dot_q <= dot_s10;
		end
	end

	// Select the row elements
	logic signed [OW-1:0] r_o [3], u_o [3], l_o [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_o[i] = $signed(mat_q[1 + i*OW +: OW]);
			u_o[i] = $signed(mat_q[1 + VEC_W + i*OW +: OW]);
			l_o[i] = $signed(mat_q[1 + 2*VEC_W + i*OW +: OW]);
		end
		out_data.row_index  = row_q;
		out_data.degenerate = mat_q[0];
		out_data.last_row   = (row_q == ROW_LAST);
		out_data.col3       = '0;
		unique case (row_q)
			ROW_X: begin
				out_data.col0 = FIELD_W'(r_o[0]);
				out_data.col1 = FIELD_W'(u_o[0]);
				out_data.col2 = FIELD_W'(l_o[0]);
			end
			ROW_Y: begin
				out_data.col0 = FIELD_W'(r_o[1]);
				out_data.col1 = FIELD_W'(u_o[1]);
				out_data.col2 = FIELD_W'(l_o[1]);
			end
			ROW_Z: begin
				out_data.col0 = FIELD_W'(r_o[2]);
				out_data.col1 = FIELD_W'(u_o[2]);
				out_data.col2 = FIELD_W'(l_o[2]);
			end
			default: begin
				out_data.col0 = dot_q[0];
				out_data.col1 = dot_q[1];
				out_data.col2 = dot_q[2];
				out_data.col3 = FIELD_W'(1) << FRAC_BITS;
			end
		endcase
	end

	assign out_valid = ser_vld_q;

	// A finished camera waiting at the pipeline end stays put
	a_end_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s10 && !take |=> vld_s10 && $stable(dot_s10[0]) && $stable(mat_s10))
		else $error("pipeline end changed while stalled");

	// Rows advance by one per accepted row
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		ser_vld_q && out_ready && (row_q != ROW_LAST) |=>
		ser_vld_q && (row_q == $past(row_q) + 2'd1))
		else $error("row counter skipped");

	// A stalled row keeps its place
	a_row_stall: assert property (@(posedge clk) disable iff (!arst_n)
		ser_vld_q && !out_ready |=> ser_vld_q && $stable(row_q))
		else $error("row moved while stalled");

	// The degenerate flag is the same on all rows of one camera
	a_deg_const: assert property (@(posedge clk) disable iff (!arst_n)
		ser_vld_q && (row_q != ROW_LAST) |=> $stable(mat_q[0]))
		else $error("degenerate changed within a camera");

endmodule
